// File: src/ic_pkg.sv
`timescale 1ns / 1ps

package ic_pkg;

  localparam int unsigned IN_VALUE_W = 32;
  localparam int unsigned INV_W      = 19;
  localparam int unsigned LEN_W      = 11;

  typedef logic signed [IN_VALUE_W-1:0] in_value_t;
  typedef logic [INV_W-1:0]             inv_t;
  typedef logic [LEN_W-1:0]             len_t;

endpackage

// File: src/ic_if.sv
`timescale 1ns / 1ps

interface ic_in_if
  import ic_pkg::*;
;
  logic      valid;
  logic      ready;
  in_value_t value;
  logic      last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ic_out_if
  import ic_pkg::*;
;
  logic valid;
  logic ready;
  inv_t inversions;
  len_t seq_length;
  logic overflow;

  modport source (output valid, output inversions, output seq_length, output overflow,
                  input ready);
  modport sink   (input valid, input inversions, input seq_length, input overflow,
                  output ready);
endinterface

// File: src/ic_store.sv
`timescale 1ns / 1ps

module ic_store #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/ic_ctrl.sv
`timescale 1ns / 1ps

module ic_ctrl #(
  parameter int unsigned MAX_LEN     = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned ADDR_W      = 10,
  parameter int unsigned CNT_W       = 11,
  parameter int unsigned RUN_W       = 19
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_key,
  input  logic                   in_last,
  output logic                   mem_we,
  output logic [ADDR_W-1:0]      mem_waddr,
  output logic [VALUE_WIDTH-1:0] mem_wdata,
  output logic                   mem_re,
  output logic [ADDR_W-1:0]      mem_raddr,
  input  logic [VALUE_WIDTH-1:0] mem_rdata,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [RUN_W-1:0]       res_run,
  output logic [CNT_W-1:0]       res_cnt,
  output logic                   res_ovf
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LEN);

  logic [1:0]             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic                   last_r, last_nxt;
  logic                   store_r, store_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   pend_r, pend_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [RUN_W-1:0]       run_r, run_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   res_valid_r, res_valid_nxt;
  logic [RUN_W-1:0]       res_run_r, res_run_nxt;
  logic [CNT_W-1:0]       res_cnt_r, res_cnt_nxt;
  logic                   res_ovf_r, res_ovf_nxt;
  logic [CNT_W-1:0]       cnt_inc;

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = res_valid_r;
  assign res_run   = res_run_r;
  assign res_cnt   = res_cnt_r;
  assign res_ovf   = res_ovf_r;
  assign cnt_inc   = cnt_r + CNT_W'(1);

  // reads only touch entries below cnt_r, the write lands on cnt_r after the scan
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    store_nxt     = store_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    run_nxt       = run_r;
    ovf_nxt       = ovf_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_run_nxt   = res_run_r;
    res_cnt_nxt   = res_cnt_r;
    res_ovf_nxt   = res_ovf_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[ADDR_W-1:0];
    mem_wdata     = key_r;
    mem_re        = 1'b0;
    mem_raddr     = idx_r[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt  = in_key;
          last_nxt = in_last;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          if (cnt_r == FULL) begin
            store_nxt = 1'b0;
            ovf_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            store_nxt = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (idx_r != cnt_r) begin
          mem_re  = 1'b1;
          idx_nxt = idx_r + CNT_W'(1);
        end
        pend_nxt = (idx_r != cnt_r);
        if (pend_r && ($signed(mem_rdata) > $signed(key_r))) begin
          run_nxt = run_r + RUN_W'(1);
        end
        if ((idx_r == cnt_r) && !pend_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!last_r) begin
          mem_we    = store_r;
          cnt_nxt   = store_r ? cnt_inc : cnt_r;
          state_nxt = ST_IDLE;
        end else if (!res_valid_r || res_ready) begin
          mem_we        = store_r;
          res_valid_nxt = 1'b1;
          res_run_nxt   = run_r;
          res_cnt_nxt   = store_r ? cnt_inc : cnt_r;
          res_ovf_nxt   = ovf_r;
          cnt_nxt       = '0;
          run_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      run_r       <= '0;
      ovf_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      run_r       <= run_nxt;
      ovf_r       <= ovf_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    last_r    <= last_nxt;
    store_r   <= store_nxt;
    idx_r     <= idx_nxt;
    res_run_r <= res_run_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_ovf_r <= res_ovf_nxt;
  end

endmodule

// File: src/inversion_counter.sv
// Inversion counter: takes a sequence of signed values, one request each, with last
// marking the final one, and on that final request returns the number of pairs whose
// earlier value is strictly greater than the later one, the stored length and an
// overflow flag. Values are kept in a single-port-read memory of MAX_LEN entries and
// each new value is compared against the stored ones, one memory read per cycle; a request
// arriving after the memory is full is dropped and sets overflow. Totals too wide for the
// result fields saturate at all-ones. The result sits in an output register, so the next
// sequence can start while it waits to be taken.
`timescale 1ns / 1ps

module inversion_counter
  import ic_pkg::*;
#(
  parameter int unsigned MAX_LEN     = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  ic_in_if.sink    in_chan,
  ic_out_if.source out_chan
);

  localparam int unsigned    ADDR_W  = $clog2(MAX_LEN);
  localparam int unsigned    CNT_W   = $clog2(MAX_LEN + 1);
  localparam longint unsigned MaxInv = longint'(MAX_LEN) * (longint'(MAX_LEN) - 1) / 2;
  localparam int unsigned    RUN_W   = (MaxInv < 2) ? 1 : $clog2(MaxInv + 1);

  logic [VALUE_WIDTH-1:0] key;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic [RUN_W-1:0]       res_run;
  logic [CNT_W-1:0]       res_cnt;

  generate
    if (VALUE_WIDTH <= IN_VALUE_W) begin : g_narrow
      assign key = in_chan.value[VALUE_WIDTH-1:0];
    end else begin : g_wide
      assign key = {{(VALUE_WIDTH - IN_VALUE_W){in_chan.value[IN_VALUE_W-1]}}, in_chan.value};
    end
  endgenerate

  ic_store #(
    .DEPTH  (MAX_LEN),
    .WIDTH  (VALUE_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ic_ctrl #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W),
    .RUN_W       (RUN_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_key    (key),
    .in_last   (in_chan.last),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (out_chan.valid),
    .res_ready (out_chan.ready),
    .res_run   (res_run),
    .res_cnt   (res_cnt),
    .res_ovf   (out_chan.overflow)
  );

  generate
    if (RUN_W > INV_W) begin : g_inv_sat
      assign out_chan.inversions = (|res_run[RUN_W-1:INV_W]) ? '1 : res_run[INV_W-1:0];
    end else begin : g_inv_fit
      assign out_chan.inversions = INV_W'(res_run);
    end
    if (CNT_W > LEN_W) begin : g_len_sat
      assign out_chan.seq_length = (|res_cnt[CNT_W-1:LEN_W]) ? '1 : res_cnt[LEN_W-1:0];
    end else begin : g_len_fit
      assign out_chan.seq_length = LEN_W'(res_cnt);
    end
  endgenerate

endmodule
